/* rtl/modular_inverse_euclid_unit_macros.svh */
// Assertion macros shared by the checker.
`ifndef MODULAR_INVERSE_EUCLID_UNIT_MACROS_SVH
`define MODULAR_INVERSE_EUCLID_UNIT_MACROS_SVH

// Implication that must hold at every clock edge outside reset.
`define MIE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define MIE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");

`endif

/* rtl/mie_pkg.sv */
`default_nettype none
package mie_pkg;
  localparam int unsigned HalfW = 64;
  localparam int unsigned WordW = 128;
  localparam int unsigned CntW  = 7;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic [HalfW-1:0] a_low;
    logic [HalfW-1:0] a_high;
    logic [HalfW-1:0] m_low;
    logic [HalfW-1:0] m_high;
  } in_item_t;

  typedef struct packed {
    logic [HalfW-1:0] inv_low;
    logic [HalfW-1:0] inv_high;
    logic             success;
  } out_item_t;
endpackage
`default_nettype wire

/* rtl/mie_if.sv */
`default_nettype none
interface mie_in_if;
  logic             valid;
  logic             ready;
  mie_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mie_out_if;
  logic              valid;
  logic              ready;
  mie_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/modular_inverse_euclid_unit.sv */
// Modular inverse of a 128-bit value a modulo a 128-bit modulus m.
// Input channel in_i carries a_low/a_high/m_low/m_high; output channel out_o
// carries inv_low/inv_high/success. Both use valid/ready; an item moves on a
// rising edge where both are high.
// One item is in work at a time: in_i.ready is high only while idle and the
// output register is free (or being taken in the same cycle).
// Each Euclid step runs a restoring divide, one quotient bit per cycle,
// then a shift-add multiply q*y, one multiplier bit per cycle, then an
// update state. A value of 0 or 1 still makes one such pass. A finish
// state then completes the item; for a modulus of 0 or 1 the result is
// registered when the item is accepted. The step count is data dependent
// (at most about 186 for 128-bit inputs); typical random 128-bit inputs
// need around 75 steps. The 128-bit subtract/compare in the divider and
// the 128-bit adder in the multiplier are each used once per bit, which
// sets the length of a step.
// Reset (rst_ni low, asynchronous) drops any item in work and empties the
// output register. A stalled receiver holds the result in the output
// register; no new item is accepted until it has been taken.
`default_nettype none
module modular_inverse_euclid_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mie_in_if.sink    in_i,
  mie_out_if.source out_o
);
  import mie_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_UPD  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Euclid working values and coefficients (sign-magnitude).
  word_t a_q, m_q, m0_q, x_q, y_q;
  logic  xs_q, ys_q;
  // Divider: quotient/dividend shift register and partial remainder.
  word_t qn_q, r_q;
  // Multiplier: multiplier bits, shifted multiplicand, accumulator.
  word_t mq_q, md_q, acc_q;
  logic [CntW-1:0] cnt_q;
  logic  ovalid_q;
  out_item_t odata_q;

  word_t one_w, rs, rsub;
  logic  rtop, rge;
  logic  out_free;

  assign one_w    = word_t'(1);
  assign out_free = !ovalid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE) && out_free;
  assign out_o.valid = ovalid_q;
  assign out_o.data  = odata_q;

  // One restoring-division bit: shift in next dividend bit, compare, subtract.
  assign rtop = r_q[WordW-1];
  assign rs   = {r_q[WordW-2:0], qn_q[WordW-1]};
  assign rsub = rs - m_q;
  assign rge  = rtop || (rs >= m_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_o.ready) ovalid_q <= 1'b0;
      // Raise the result in the cycles that finish an item.
      if (state_q == S_IDLE && in_i.valid && in_i.ready &&
          ({in_i.data.m_high, in_i.data.m_low} <= one_w)) ovalid_q <= 1'b1;
      if (state_q == S_FIN) ovalid_q <= 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid && in_i.ready &&
            ({in_i.data.m_high, in_i.data.m_low} > one_w)) state_d = S_DIV;
        else if (in_i.valid && in_i.ready) state_d = S_IDLE;
      end
      S_DIV: begin
        if (cnt_q == '1) state_d = S_MUL;
      end
      S_MUL: begin
        if (cnt_q == '1) state_d = S_UPD;
      end
      S_UPD: begin
        // Next loop test on the new a (old m) and new m (remainder).
        if (m_q > one_w && r_q != '0) state_d = S_DIV;
        else state_d = S_FIN;
      end
      S_FIN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        a_q  <= {in_i.data.a_high, in_i.data.a_low};
        m_q  <= {in_i.data.m_high, in_i.data.m_low};
        m0_q <= {in_i.data.m_high, in_i.data.m_low};
        qn_q <= {in_i.data.a_high, in_i.data.a_low};
        r_q  <= '0;
        x_q  <= one_w;
        y_q  <= '0;
        xs_q <= 1'b0;
        ys_q <= 1'b0;
        cnt_q <= '0;
        if (in_i.valid && in_i.ready) odata_q <= '0;
      end
      S_DIV: begin
        // a <= one never enters the loop; skip the division work and leave qn_q unchanged.
        if (a_q > one_w) begin
          r_q  <= rge ? rsub : rs;
          qn_q <= {qn_q[WordW-2:0], rge};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          mq_q  <= '0;
          md_q  <= y_q;
          acc_q <= '0;
        end
      end
      S_MUL: begin
        // Consume quotient bits from the LSB while the multiplicand moves up.
        if (cnt_q == '0) begin
          mq_q <= {1'b0, qn_q[WordW-1:1]};
          md_q <= {y_q[WordW-2:0], 1'b0};
          acc_q <= qn_q[0] ? y_q : '0;
        end else begin
          mq_q <= {1'b0, mq_q[WordW-1:1]};
          md_q <= {md_q[WordW-2:0], 1'b0};
          acc_q <= mq_q[0] ? acc_q + md_q : acc_q;
        end
        cnt_q <= cnt_q + 1'b1;
      end
      S_UPD: begin
        if (a_q > one_w) begin
          a_q <= m_q;
          m_q <= r_q;
          if (xs_q == ys_q) begin
            if (x_q >= acc_q) begin
              y_q <= x_q - acc_q;
              ys_q <= xs_q;
            end else begin
              y_q <= acc_q - x_q;
              ys_q <= !xs_q;
            end
          end else begin
            y_q <= x_q + acc_q;
            ys_q <= xs_q;
          end
          x_q  <= y_q;
          xs_q <= ys_q;
          qn_q <= m_q;
        end
        r_q   <= '0;
        cnt_q <= '0;
      end
      S_FIN: begin
        if (a_q == one_w) begin
          odata_q.success <= 1'b1;
          if (xs_q && x_q != '0) {odata_q.inv_high, odata_q.inv_low} <= m0_q - x_q;
          else {odata_q.inv_high, odata_q.inv_low} <= x_q;
        end else begin
          odata_q <= '0;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/mie_checker.sv */
`default_nettype none
`include "modular_inverse_euclid_unit_macros.svh"
module mie_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_success,
  input wire logic [63:0] out_inv_low,
  input wire logic [63:0] out_inv_high
);
  logic         out_stall;
  logic         inv_zero;
  logic [128:0] out_payload;

  assign out_stall   = out_valid && !out_ready;
  assign inv_zero    = (out_inv_low == '0) && (out_inv_high == '0);
  assign out_payload = {out_success, out_inv_high, out_inv_low};

  `MIE_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, out_valid && !out_success, inv_zero)
  `MIE_ASSERT_IMP(a_busy_full, clk_i, rst_ni, out_stall, !in_ready)
  `MIE_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_stall, out_valid && $stable(out_payload))
endmodule

bind modular_inverse_euclid_unit mie_checker u_mie_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .out_success(out_o.data.success),
  .out_inv_low(out_o.data.inv_low), .out_inv_high(out_o.data.inv_high)
);
`default_nettype wire
